[design/arl_pkg.sv]
// arl_pkg: shared types, register indexes and constants for the actuator rate limiter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package arl_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int DATA_W      = 16;
	localparam int APB_AW      = 4;
	localparam int APB_DW      = 32;

	typedef enum logic [1:0] {
		REG_SLEW_RATE   = 2'd0,
		REG_LIMIT_LOW   = 2'd1,
		REG_LIMIT_HIGH  = 2'd2,
		REG_INPUT_BOUND = 2'd3
	} reg_idx_t;

	localparam logic        [DATA_W-1:0] SLEW_RATE_RESET  = 16'd2048;
	localparam logic signed [DATA_W-1:0] LIMIT_LOW_RESET  = -16'sd4915;
	localparam logic signed [DATA_W-1:0] LIMIT_HIGH_RESET = 16'sd4915;

	// 3.0 in Q.15, scaled from 3 - 2|x|
	localparam logic [16:0] SHAPE_K = 17'd98304;
	// smoothing gain 10 rad^-1 seen from Q.14 error into Q.16
	localparam logic [5:0]  SMOOTH_GAIN = 6'd40;
	// 1.0 in Q.16
	localparam logic [16:0] SMOOTH_MAX = 17'd65536;

	typedef struct packed {
		logic        [DATA_W-1:0] slew_rate;
		logic signed [DATA_W-1:0] limit_low;
		logic signed [DATA_W-1:0] limit_high;
		logic                     input_bound;
	} cfg_t;

	typedef struct packed {
		logic              neg;
		logic [DATA_W-1:0] mag;
		logic [DATA_W-1:0] dt;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

[design/arl_regs.sv]
// arl_regs: apb configuration registers of the actuator rate limiter
// depends on arl_pkg
`timescale 1ns / 1ps
`default_nettype none

module arl_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [arl_pkg::APB_AW-1:0]  paddr,
	input  wire logic [arl_pkg::APB_DW-1:0]  pwdata,
	output logic      [arl_pkg::APB_DW-1:0]  prdata,
	output logic                             pready,
	output arl_pkg::cfg_t                    cfg
);

	arl_pkg::cfg_t     cfg_q;
	arl_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = arl_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slew_rate   <= arl_pkg::SLEW_RATE_RESET;
			cfg_q.limit_low   <= arl_pkg::LIMIT_LOW_RESET;
			cfg_q.limit_high  <= arl_pkg::LIMIT_HIGH_RESET;
			cfg_q.input_bound <= 1'b1;
		end else if (wr_en) begin
			unique case (idx)
				arl_pkg::REG_SLEW_RATE:   cfg_q.slew_rate   <= pwdata[15:0];
				arl_pkg::REG_LIMIT_LOW:   cfg_q.limit_low   <= pwdata[15:0];
				arl_pkg::REG_LIMIT_HIGH:  cfg_q.limit_high  <= pwdata[15:0];
				arl_pkg::REG_INPUT_BOUND: cfg_q.input_bound <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			arl_pkg::REG_SLEW_RATE:   prdata = {16'b0, cfg_q.slew_rate};
			arl_pkg::REG_LIMIT_LOW:   prdata = {{16{cfg_q.limit_low[15]}}, cfg_q.limit_low};
			arl_pkg::REG_LIMIT_HIGH:  prdata = {{16{cfg_q.limit_high[15]}}, cfg_q.limit_high};
			arl_pkg::REG_INPUT_BOUND: prdata = {31'b0, cfg_q.input_bound};
		endcase
	end

endmodule

`default_nettype wire

[design/arl_queue.sv]
// arl_queue: short item queue between the front and back of the rate limiter
// depends on arl_pkg
`timescale 1ns / 1ps
`default_nettype none

module arl_queue #(
	parameter int DEPTH = arl_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire arl_pkg::item_t wr_item,
	input  wire logic           rd_en,
	output arl_pkg::item_t      rd_item,
	output arl_pkg::q_stat_t    stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	arl_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           do_wr;
	logic           do_rd;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_wr      = wr_en & ~stat.full;
	assign do_rd      = rd_en & ~stat.empty;
	assign rd_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr & ~do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd & ~do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

[design/arl_front.sv]
// arl_front: input side, accepts command items and splits them into sign and magnitude
// depends on arl_pkg
`timescale 1ns / 1ps
`default_nettype none

module arl_front (
	input  wire logic                 push,
	output logic                      full,
	input  wire logic signed [15:0]   command,
	input  wire logic        [15:0]   tick_seconds,
	input  wire arl_pkg::q_stat_t     q_stat,
	output logic                      q_wr,
	output arl_pkg::item_t            q_item
);

	assign full        = q_stat.full;
	assign q_wr        = push & ~q_stat.full;
	assign q_item.neg  = command[15];
	// magnitude of the most negative command is 32768, still fits unsigned
	assign q_item.mag  = command[15] ? (~command + 16'd1) : command;
	assign q_item.dt   = tick_seconds;

endmodule

`default_nettype wire

[design/arl_back.sv]
// arl_back: sequencer that shapes the target, computes the slew step and updates the angle
// depends on arl_pkg
`timescale 1ns / 1ps
`default_nettype none

module arl_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire arl_pkg::cfg_t        cfg,
	input  wire arl_pkg::q_stat_t     q_stat,
	input  wire arl_pkg::item_t       q_item,
	output logic                      q_rd,
	input  wire logic                 pop,
	output logic                      empty,
	output logic signed [15:0]        deflection
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_CUBE  = 8'b0000_0010,
		ST_RND   = 8'b0000_0100,
		ST_SCALE = 8'b0000_1000,
		ST_TGT   = 8'b0001_0000,
		ST_ERR   = 8'b0010_0000,
		ST_STEP  = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	localparam logic [60:0] RND61 = 61'd1 << 29;
	localparam logic [45:0] RND46 = 46'd1 << 29;
	localparam logic [48:0] RND49 = 49'd1 << 29;

	state_t state_q;
	state_t state_d;

	logic               neg_q;
	logic [30:0]        a2_q;
	logic [30:0]        ak_q;
	logic [31:0]        sd_q;
	logic [60:0]        m60_q;
	logic [30:0]        m30_q;
	logic [45:0]        tprod_q;
	logic signed [15:0] target_q;
	logic [16:0]        s_q;
	logic               rising_q;
	logic [48:0]        sprod_q;
	logic signed [15:0] cur_q;
	logic signed [15:0] defl_q;
	logic               out_valid_q;

	logic [16:0]        k_w;
	logic [31:0]        a2_w;
	logic [32:0]        ak_w;
	logic [31:0]        sd_w;
	logic [61:0]        m60_w;
	logic [60:0]        m30_w;
	logic [15:0]        lo_mag;
	logic [15:0]        hi_mag;
	logic [15:0]        scale;
	logic [46:0]        tprod_w;
	logic [45:0]        tr_w;
	logic [15:0]        t_w;
	logic signed [15:0] target_w;
	logic signed [16:0] diff_w;
	logic [16:0]        err_w;
	logic [22:0]        s40_w;
	logic [48:0]        sprod_w;
	logic [48:0]        step_full;
	logic [18:0]        step_w;
	logic signed [20:0] cur_x;
	logic signed [20:0] rise_w;
	logic signed [20:0] fall_w;
	logic signed [20:0] lim_lo_x;
	logic signed [20:0] lim_hi_x;
	logic signed [15:0] next_w;
	logic               start;
	logic               done_fire;

	assign start     = (state_q == ST_IDLE) & ~q_stat.empty;
	assign done_fire = (state_q == ST_DONE) & (~out_valid_q | pop);
	assign q_rd      = start;
	assign empty     = ~out_valid_q;
	assign deflection = defl_q;

	// shaping products
	assign k_w   = arl_pkg::SHAPE_K - {q_item.mag, 1'b0};
	assign a2_w  = {16'b0, q_item.mag} * {16'b0, q_item.mag};
	assign ak_w  = {17'b0, q_item.mag} * {16'b0, k_w};
	assign sd_w  = {16'b0, cfg.slew_rate} * {16'b0, q_item.dt};
	assign m60_w = {31'b0, a2_q} * {31'b0, ak_q};
	assign m30_w = m60_q + RND61;

	// scale by the larger limit magnitude
	assign lo_mag  = cfg.limit_low[15] ? (~cfg.limit_low + 16'd1) : cfg.limit_low;
	assign hi_mag  = cfg.limit_high[15] ? (~cfg.limit_high + 16'd1) : cfg.limit_high;
	assign scale   = (lo_mag > hi_mag) ? lo_mag : hi_mag;
	assign tprod_w = {16'b0, m30_q} * {31'b0, scale};
	assign tr_w    = tprod_q + RND46;
	assign t_w     = tr_w[45:30];

	always_comb begin
		priority if (!cfg.input_bound) begin
			target_w = '0;
		end else if (neg_q) begin
			target_w = ~t_w + 16'd1;
		end else if (t_w[15]) begin
			target_w = 16'sh7fff;
		end else begin
			target_w = t_w;
		end
	end

	// error and smoothing factor
	assign diff_w  = {cur_q[15], cur_q} - {target_q[15], target_q};
	assign err_w   = diff_w[16] ? (~diff_w + 17'd1) : diff_w;
	assign s40_w   = {6'b0, err_w} * {17'b0, arl_pkg::SMOOTH_GAIN};
	assign sprod_w = {32'b0, s_q} * {17'b0, sd_q};

	// step and clamp
	assign step_full = sprod_q + RND49;
	assign step_w    = step_full[48:30];
	assign cur_x     = {{5{cur_q[15]}}, cur_q};
	assign rise_w    = cur_x + {2'b0, step_w};
	assign fall_w    = cur_x - {2'b0, step_w};
	assign lim_lo_x  = {{5{cfg.limit_low[15]}}, cfg.limit_low};
	assign lim_hi_x  = {{5{cfg.limit_high[15]}}, cfg.limit_high};

	always_comb begin
		if (rising_q) begin
			next_w = (rise_w > lim_hi_x) ? cfg.limit_high : rise_w[15:0];
		end else begin
			next_w = (fall_w < lim_lo_x) ? cfg.limit_low : fall_w[15:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_CUBE;
			ST_CUBE:  state_d = ST_RND;
			ST_RND:   state_d = ST_SCALE;
			ST_SCALE: state_d = ST_TGT;
			ST_TGT:   state_d = ST_ERR;
			ST_ERR:   state_d = ST_STEP;
			ST_STEP:  state_d = ST_DONE;
			ST_DONE:  if (done_fire) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cur_q       <= '0;
		end else begin
			state_q <= state_d;
			if (done_fire) begin
				out_valid_q <= 1'b1;
				cur_q       <= next_w;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= q_item.neg;
			a2_q  <= a2_w[30:0];
			ak_q  <= ak_w[30:0];
			sd_q  <= sd_w;
		end
		if (state_q == ST_CUBE) begin
			m60_q <= m60_w[60:0];
		end
		if (state_q == ST_RND) begin
			m30_q <= m30_w[60:30];
		end
		if (state_q == ST_SCALE) begin
			tprod_q <= tprod_w[45:0];
		end
		if (state_q == ST_TGT) begin
			target_q <= target_w;
		end
		if (state_q == ST_ERR) begin
			s_q      <= (s40_w > {6'b0, arl_pkg::SMOOTH_MAX}) ? arl_pkg::SMOOTH_MAX : s40_w[16:0];
			rising_q <= diff_w[16];
		end
		if (state_q == ST_STEP) begin
			sprod_q <= sprod_w;
		end
		if (done_fire) begin
			defl_q <= next_w;
		end
	end

endmodule

`default_nettype wire

[design/actuator_rate_limiter_core.sv]
// actuator_rate_limiter_core: top level of one actuator rate limiter channel
// depends on arl_pkg, arl_regs, arl_front, arl_queue, arl_back
//
//   channel   signals                                  direction
//   config    psel penable pwrite paddr pwdata         in
//             prdata pready                            out
//   input     push command tick_seconds / full         in / out
//   result    pop / empty deflection                   in / out
//
// each item passes through the back sequencer as a chain of steps (a^2 and
// a*(3-2a), cube, round, limit scale, target, error, step product, clamp); the
// front keeps taking items into the queue meanwhile, as long as the queue has room.
// reset empties the queue and the result register and sets the stored angle to zero.
// a result that is not popped holds the sequencer in its last step.
`timescale 1ns / 1ps
`default_nettype none

module actuator_rate_limiter_core #(
	parameter int QUEUE_DEPTH = arl_pkg::QUEUE_DEPTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [arl_pkg::APB_AW-1:0]  paddr,
	input  wire logic [arl_pkg::APB_DW-1:0]  pwdata,
	output logic      [arl_pkg::APB_DW-1:0]  prdata,
	output logic                             pready,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic signed [15:0]          command,
	input  wire logic        [15:0]          tick_seconds,
	input  wire logic                        pop,
	output logic                             empty,
	output logic signed [15:0]               deflection
);

	arl_pkg::cfg_t    cfg;
	arl_pkg::q_stat_t q_stat;
	arl_pkg::item_t   wr_item;
	arl_pkg::item_t   rd_item;
	logic             q_wr;
	logic             q_rd;

	arl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	arl_front u_front (
		.push         (push),
		.full         (full),
		.command      (command),
		.tick_seconds (tick_seconds),
		.q_stat       (q_stat),
		.q_wr         (q_wr),
		.q_item       (wr_item)
	);

	arl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_item (wr_item),
		.rd_en   (q_rd),
		.rd_item (rd_item),
		.stat    (q_stat)
	);

	arl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_stat     (q_stat),
		.q_item     (rd_item),
		.q_rd       (q_rd),
		.pop        (pop),
		.empty      (empty),
		.deflection (deflection)
	);

endmodule

`default_nettype wire
